// File: hw/rtl/lpcv_pkg.sv
// Shared types, constants and decode functions for the LPC lattice speech voice.
`default_nettype none

package lpcv_pkg;

   // Field widths
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned COEF_W   = 10;
   localparam int unsigned AMP_W    = 12;
   localparam int unsigned NOISE_W  = 15;
   localparam int unsigned PITCH_W  = 8;
   localparam int unsigned DAC_W    = 7;
   localparam int unsigned STAGE_W  = 4;

   // Register slot codes
   typedef enum logic [3:0] {
      SLOT_B0     = 4'd0,
      SLOT_F0     = 4'd1,
      SLOT_AMP    = 4'd2,
      SLOT_B1     = 4'd3,
      SLOT_F1     = 4'd4,
      SLOT_PITCH  = 4'd5,
      SLOT_B2     = 4'd6,
      SLOT_F2     = 4'd7,
      SLOT_VOICED = 4'd8,
      SLOT_B3     = 4'd9,
      SLOT_F3     = 4'd10,
      SLOT_B4     = 4'd11,
      SLOT_F4     = 4'd12,
      SLOT_B5     = 4'd13,
      SLOT_F5     = 4'd14,
      SLOT_NONE   = 4'd15
   } slot_type;

   // Transaction kinds on the request channel
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   // Coefficient write aimed at one cell
   typedef struct packed {
      logic                     load_f;
      logic                     load_b;
      logic signed [COEF_W-1:0] coef;
   } cell_cmd_type;

   // Command to the excitation source
   typedef struct packed {
      logic       tick;
      logic       wr_amp;
      logic       wr_pitch;
      logic       wr_voiced;
      logic [7:0] data;
   } src_cmd_type;

   // Decoded coefficient target of a slot
   typedef struct packed {
      logic               is_coef;
      logic               is_fwd;
      logic [STAGE_W-1:0] stage;
   } coef_sel_type;

   // Coefficient magnitude ROM
   localparam logic [8:0] COEF_ROM [128] = '{
      9'd0,   9'd9,   9'd17,  9'd25,  9'd33,  9'd41,  9'd49,  9'd57,
      9'd65,  9'd73,  9'd81,  9'd89,  9'd97,  9'd105, 9'd113, 9'd121,
      9'd129, 9'd137, 9'd145, 9'd153, 9'd161, 9'd169, 9'd177, 9'd185,
      9'd193, 9'd201, 9'd209, 9'd217, 9'd225, 9'd233, 9'd241, 9'd249,
      9'd257, 9'd265, 9'd273, 9'd281, 9'd289, 9'd297, 9'd301, 9'd305,
      9'd309, 9'd313, 9'd317, 9'd321, 9'd325, 9'd329, 9'd333, 9'd337,
      9'd341, 9'd345, 9'd349, 9'd353, 9'd357, 9'd361, 9'd365, 9'd369,
      9'd373, 9'd377, 9'd381, 9'd385, 9'd389, 9'd393, 9'd397, 9'd401,
      9'd405, 9'd409, 9'd413, 9'd417, 9'd421, 9'd425, 9'd427, 9'd429,
      9'd431, 9'd433, 9'd435, 9'd437, 9'd439, 9'd441, 9'd443, 9'd445,
      9'd447, 9'd449, 9'd451, 9'd453, 9'd455, 9'd457, 9'd459, 9'd461,
      9'd463, 9'd465, 9'd467, 9'd469, 9'd471, 9'd473, 9'd475, 9'd477,
      9'd479, 9'd481, 9'd482, 9'd483, 9'd484, 9'd485, 9'd486, 9'd487,
      9'd488, 9'd489, 9'd490, 9'd491, 9'd492, 9'd493, 9'd494, 9'd495,
      9'd496, 9'd497, 9'd498, 9'd499, 9'd500, 9'd501, 9'd502, 9'd503,
      9'd504, 9'd505, 9'd506, 9'd507, 9'd508, 9'd509, 9'd510, 9'd511
   };

   // Magnitude from the ROM, positive when bit 7 is set
   function automatic logic signed [COEF_W-1:0] coef_decode(input logic [7:0] b);
      logic signed [COEF_W-1:0] mag;
      begin
         mag = $signed({1'b0, COEF_ROM[b[6:0]]});
         coef_decode = b[7] ? mag : -mag;
      end
   endfunction

   // Map a slot to its stage and direction
   function automatic coef_sel_type slot_to_coef(input slot_type slot);
      coef_sel_type sel;
      begin
         sel = '0;
         case (slot)
            SLOT_B0: begin sel = '{1'b1, 1'b0, STAGE_W'(0)}; end
            SLOT_F0: begin sel = '{1'b1, 1'b1, STAGE_W'(0)}; end
            SLOT_B1: begin sel = '{1'b1, 1'b0, STAGE_W'(1)}; end
            SLOT_F1: begin sel = '{1'b1, 1'b1, STAGE_W'(1)}; end
            SLOT_B2: begin sel = '{1'b1, 1'b0, STAGE_W'(2)}; end
            SLOT_F2: begin sel = '{1'b1, 1'b1, STAGE_W'(2)}; end
            SLOT_B3: begin sel = '{1'b1, 1'b0, STAGE_W'(3)}; end
            SLOT_F3: begin sel = '{1'b1, 1'b1, STAGE_W'(3)}; end
            SLOT_B4: begin sel = '{1'b1, 1'b0, STAGE_W'(4)}; end
            SLOT_F4: begin sel = '{1'b1, 1'b1, STAGE_W'(4)}; end
            SLOT_B5: begin sel = '{1'b1, 1'b0, STAGE_W'(5)}; end
            SLOT_F5: begin sel = '{1'b1, 1'b1, STAGE_W'(5)}; end
            default: begin sel = '0; end
         endcase
         slot_to_coef = sel;
      end
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lpcv_cell.sv
// One lattice stage cell: coefficients, two delays, and a registered sum toward the next cell.
`default_nettype none

module lpcv_cell
   import lpcv_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cell_cmd_type               cmd,
   input  wire logic                       go_in,
   input  wire logic signed [SAMPLE_W-1:0] z_in,
   output logic                            go_out,
   output logic signed [SAMPLE_W-1:0]      z_out
);

   logic signed [COEF_W-1:0]          coef_f_ff, coef_b_ff;
   logic signed [SAMPLE_W-1:0]        z1_ff, z2_ff;
   logic signed [SAMPLE_W-1:0]        term_f_ff, term_b_ff;
   logic                              go_ff;
   logic signed [SAMPLE_W+COEF_W-1:0] prod_f, prod_b;
   logic signed [SAMPLE_W-1:0]        z0_in;

   // Products from the held delays; floor shift, then keep the low 16 bits
   assign prod_f = z1_ff * coef_f_ff;
   assign prod_b = z2_ff * coef_b_ff;

   // Wrapping sum of the incoming sample and both feedback terms
   assign z0_in = z_in + term_f_ff + term_b_ff;

   // Hold coefficients, delays and the wave flag
   always_ff @(posedge clock) begin
      term_f_ff <= prod_f[SAMPLE_W+7:8];
      term_b_ff <= prod_b[SAMPLE_W+8:9];
      if (reset) begin
         coef_f_ff <= '0;
         coef_b_ff <= '0;
         z1_ff     <= '0;
         z2_ff     <= '0;
         go_ff     <= 1'b0;
      end else begin
         go_ff <= go_in;
         if (cmd.load_f) begin
            coef_f_ff <= cmd.coef;
         end
         if (cmd.load_b) begin
            coef_b_ff <= cmd.coef;
         end
         if (go_in) begin
            z2_ff <= z1_ff;
            z1_ff <= z0_in;
         end
      end
   end

   assign go_out = go_ff;
   assign z_out  = z1_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lpcv_src.sv
// Excitation source: noise LFSR, pitch counter, amplitude and voiced flag.
`default_nettype none

module lpcv_src
   import lpcv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire src_cmd_type           cmd,
   output logic                       exc_valid,
   output logic signed [SAMPLE_W-1:0] exc
);

   logic [AMP_W-1:0]           amp_ff;
   logic [NOISE_W-1:0]         noise_ff;
   logic [PITCH_W-1:0]         period_ff, count_ff;
   logic                       voiced_ff;
   logic                       exc_valid_ff;
   logic signed [SAMPLE_W-1:0] exc_ff;
   logic [NOISE_W-1:0]         noise_in;
   logic [PITCH_W-1:0]         count_in;
   logic signed [SAMPLE_W-1:0] amp_pos, exc_in;

   // Step the LFSR: feedback of the two low bits enters at the top
   assign noise_in = {noise_ff[0] ^ noise_ff[1], noise_ff[NOISE_W-1:1]};

   // Wrap the pitch counter at the period
   assign count_in = (count_ff >= period_ff) ? '0 : count_ff + PITCH_W'(1);

   // Pick pulse or signed noise excitation
   assign amp_pos = $signed(SAMPLE_W'(amp_ff));
   always_comb begin
      if (voiced_ff) begin
         exc_in = (count_ff == '0) ? amp_pos : '0;
      end else begin
         exc_in = noise_in[0] ? amp_pos : -amp_pos;
      end
   end

   // Hold source state; register the excitation for the first cell
   always_ff @(posedge clock) begin
      if (cmd.tick) begin
         exc_ff <= exc_in;
      end
      if (reset) begin
         amp_ff       <= '0;
         noise_ff     <= '1;
         period_ff    <= PITCH_W'(22);
         count_ff     <= '0;
         voiced_ff    <= 1'b1;
         exc_valid_ff <= 1'b0;
      end else begin
         exc_valid_ff <= cmd.tick;
         if (cmd.tick) begin
            noise_ff <= noise_in;
            count_ff <= count_in;
         end
         if (cmd.wr_amp) begin
            amp_ff <= AMP_W'(cmd.data[4:0]) << cmd.data[7:5];
         end
         if (cmd.wr_pitch) begin
            period_ff <= cmd.data;
         end
         if (cmd.wr_voiced) begin
            voiced_ff <= cmd.data[6];
         end
      end
   end

   assign exc_valid = exc_valid_ff;
   assign exc       = exc_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lpc_lattice_speech_voice_unit.sv
// Top level of one LPC lattice speech voice: request decode, cell chain, output register.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_action, req_reg_index, req_reg_data
//   rsp     | out       | rsp_valid/rsp_stall | rsp_dac_sample
//
// A register write is applied when it is accepted. A tick registers the excitation in the
// source, walks the sample down the chain through each lattice cell in turn, and then loads
// the clamped sample into the output register, once that register is free.
// A tick may be accepted while the previous sample still waits in the output register.
// Reset is synchronous; control, coefficient and source state return to power-up values.
`default_nettype none

module lpc_lattice_speech_voice_unit
   import lpcv_pkg::*;
#(
   parameter int unsigned STAGES = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_action,
   input  wire logic [3:0]        req_reg_index,
   input  wire logic [7:0]        req_reg_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic signed [DAC_W-1:0] rsp_dac_sample
);

   logic                       busy_ff, pend_ff, rsp_valid_ff;
   logic signed [DAC_W-1:0]    rsp_dac_ff;
   logic                       req_acc, wr_acc, tick_acc;
   slot_type                   slot;
   coef_sel_type               sel;
   src_cmd_type                src_cmd;
   logic                       go_w [STAGES+1];
   logic signed [SAMPLE_W-1:0] z_w  [STAGES+1];
   logic [STAGES:0]            go_vec;
   logic                       done, load_rsp;
   logic signed [9:0]          z_div;
   logic signed [DAC_W-1:0]    dac_in;

   // Accept one transaction at a time while no sample walks the chain
   assign req_stall = busy_ff;
   assign req_acc   = req_valid && !req_stall;
   assign wr_acc    = req_acc && (req_action == ACT_WRITE);
   assign tick_acc  = req_acc && (req_action == ACT_TICK);

   // Decode the register slot
   assign slot = slot_type'(req_reg_index);
   assign sel  = slot_to_coef(slot);

   always_comb begin
      src_cmd           = '0;
      src_cmd.tick      = tick_acc;
      src_cmd.data      = req_reg_data;
      src_cmd.wr_amp    = wr_acc && (slot == SLOT_AMP);
      src_cmd.wr_pitch  = wr_acc && (slot == SLOT_PITCH);
      src_cmd.wr_voiced = wr_acc && (slot == SLOT_VOICED);
   end

   lpcv_src u_src (
      .clock     (clock),
      .reset     (reset),
      .cmd       (src_cmd),
      .exc_valid (go_w[0]),
      .exc       (z_w[0])
   );

   // Chain of lattice cells; a write naming a stage past the chain hits no cell
   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      cell_cmd_type cmd;
      always_comb begin
         cmd.coef   = coef_decode(req_reg_data);
         cmd.load_f = wr_acc && sel.is_coef && sel.is_fwd && (sel.stage == STAGE_W'(i));
         cmd.load_b = wr_acc && sel.is_coef && !sel.is_fwd && (sel.stage == STAGE_W'(i));
      end
      lpcv_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .cmd    (cmd),
         .go_in  (go_w[i]),
         .z_in   (z_w[i]),
         .go_out (go_w[i+1]),
         .z_out  (z_w[i+1])
      );
   end

   for (genvar j = 0; j <= STAGES; j++) begin : g_go
      assign go_vec[j] = go_w[j];
   end

   // Shift right by 6 and clamp to the DAC range
   assign z_div = z_w[STAGES][SAMPLE_W-1:6];
   always_comb begin
      if (z_div > 10'sd63) begin
         dac_in = 7'sd63;
      end else if (z_div < -10'sd64) begin
         dac_in = -7'sd64;
      end else begin
         dac_in = z_div[DAC_W-1:0];
      end
   end

   // Load the output register once it is free; hold the sample in the last cell until then
   assign done     = go_w[STAGES] || pend_ff;
   assign load_rsp = done && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_dac_ff <= dac_in;
      end
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (tick_acc) begin
            busy_ff <= 1'b1;
         end else if (load_rsp) begin
            busy_ff <= 1'b0;
         end
         pend_ff <= done && !load_rsp;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dac_sample = rsp_dac_ff;

   // At most one sample walks the chain
   a_one_wave: assert property (@(posedge clock) disable iff (reset)
      $onehot0(go_vec))
      else $error("more than one sample in the cell chain");

   // A waiting sample only exists while a tick is in flight
   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> busy_ff)
      else $error("pending sample without a tick in flight");

   // The wave only moves while a tick is in flight
   a_wave_busy: assert property (@(posedge clock) disable iff (reset)
      (go_vec != '0) |-> busy_ff)
      else $error("chain active while idle");

   // A new result comes only from a tick that was in flight
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> busy_ff)
      else $error("result loaded without a tick");

endmodule

`default_nettype wire
